/* hdl/assert_macros.svh */
// Assertion macros shared by the yaw-rate tracker RTL.
// The macros expect signals named clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define KZU_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion violated");

// When the antecedent holds, the consequent must hold in the same cycle.
`define KZU_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion violated");

`endif

/* hdl/kzu_pkg.sv */
// Package for the yaw-rate Kalman tracker: widths, fixed-point constants, codes.
// Used by all modules of the block; depends on nothing.
package kzu_pkg;

    localparam int RATE_W     = 28;     // shared multiplier operand A width
    localparam int MB_W       = 25;     // shared multiplier operand B width
    localparam int PROD_W     = RATE_W + MB_W;

    localparam int QUIET_TICKS     = 5;
    localparam int TURN_HOLD_TICKS = 25;

    localparam logic signed [26:0] RATE_MAX = 27'sd67108863;
    localparam logic signed [26:0] RATE_MIN = -27'sd67108864;
    localparam logic signed [29:0] FULL_TURN = 30'sd23592960;
    localparam logic [17:0] COV_MAX      = 18'd262143;
    localparam logic [17:0] COV_RESET    = 18'd65536;
    localparam logic signed [26:0] QUIET_LIMIT = 27'sd39322;
    localparam logic signed [26:0] SLOW_LIMIT  = 27'sd327680;
    localparam logic signed [26:0] FAST_LIMIT  = 27'sd1966080;
    localparam logic signed [24:0] RESIDUE_TRIP = 25'sd16384;

    localparam logic [17:0] Q_SLOW = 18'd1311;
    localparam logic [17:0] Q_MID  = 18'd6554;
    localparam logic [17:0] Q_FAST = 18'd32768;
    localparam logic [12:0] LEAK_GAIN = 13'd6554;

    localparam logic [17:0] NOISE_R_RESET     = 18'd32768;
    localparam logic [15:0] TICK_PERIOD_RESET = 16'd1311;
    localparam logic [23:0] RATE_SCALE_RESET  = 24'd171196;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_R     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_LOAD   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_SCALE  = 8'd3;

    // Divider: 35-bit dividend, 19-bit divisor, 17-bit quotient.
    localparam int DIV_NUM_W = 35;
    localparam int DIV_DEN_W = 19;
    localparam int DIV_Q_W   = 17;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

/* hdl/kzu_mul.sv */
// Shared signed multiplier with a registered product for the yaw-rate tracker.
// Depends on kzu_pkg for operand widths.
module kzu_mul (
    input  logic                              clk,
    input  logic signed [kzu_pkg::RATE_W-1:0] a,
    input  logic signed [kzu_pkg::MB_W-1:0]   b,
    output logic signed [kzu_pkg::PROD_W-1:0] prod
);

    logic signed [kzu_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= kzu_pkg::PROD_W'(a) * kzu_pkg::PROD_W'(b);
    end

    assign prod = prod_reg;

endmodule

/* hdl/kzu_div.sv */
// Restoring divider, one quotient bit per cycle, for the Kalman gain.
// Depends on kzu_pkg for widths and the status struct.
module kzu_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [kzu_pkg::DIV_NUM_W-1:0]      num,
    input  logic [kzu_pkg::DIV_DEN_W-1:0]      den,
    output logic [kzu_pkg::DIV_Q_W-1:0]        quot,
    output kzu_pkg::div_status_t               status
);

    localparam int CNT_W = $clog2(kzu_pkg::DIV_Q_W + 1);

    logic [kzu_pkg::DIV_DEN_W-1:0] rem_reg;
    logic [kzu_pkg::DIV_DEN_W-1:0] den_reg;
    logic [kzu_pkg::DIV_Q_W-1:0]   low_reg;
    logic [kzu_pkg::DIV_Q_W-1:0]   quot_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;

    logic [kzu_pkg::DIV_DEN_W:0]   rem_sh;
    logic                          fits;

    assign rem_sh = {rem_reg, low_reg[kzu_pkg::DIV_Q_W-1]};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                // The quotient fits in DIV_Q_W bits, so the top part is below den.
                rem_reg  <= kzu_pkg::DIV_DEN_W'(num[kzu_pkg::DIV_NUM_W-1:kzu_pkg::DIV_Q_W]);
                low_reg  <= num[kzu_pkg::DIV_Q_W-1:0];
                den_reg  <= den;
                quot_reg <= '0;
                cnt_reg  <= CNT_W'(kzu_pkg::DIV_Q_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg  <= fits ? kzu_pkg::DIV_DEN_W'(rem_sh - {1'b0, den_reg})
                                 : kzu_pkg::DIV_DEN_W'(rem_sh);
                low_reg  <= {low_reg[kzu_pkg::DIV_Q_W-2:0], 1'b0};
                quot_reg <= {quot_reg[kzu_pkg::DIV_Q_W-2:0], fits};
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quot        = quot_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

/* hdl/yaw_rate_kalman_zupt_unit.sv */
// Top level of the yaw-rate Kalman tracker with zero-velocity update.
// Depends on kzu_pkg, kzu_mul, kzu_div and assert_macros.svh.
//
// Usage: one raw gyro request enters on gyro_valid/gyro_ready with
// gyro_sample. The block then works on it alone: a small sequencer runs every
// product through one shared registered multiplier and the Kalman gain
// through a one-bit-per-cycle divider. The very first request skips the
// filter and the divider, and when the heading is held the heading wrap
// step is skipped. A new request can be taken once the result is loaded.
// The result leaves on res_valid/res_ready with yaw_angle, filtered_rate,
// bias_now and still_flag. It sits in an output register, so a new request
// is taken while it waits; if the receiver still stalls when the next result
// is ready, the sequencer holds it until the register frees up. Configuration
// writes use cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high, writes belong to idle time, and indexes beyond three are
// ignored. Writing bias_load also loads the tracked bias. Reset restores the
// default registers, clears the filter state and the output register, and no
// clearing pass is needed.
`include "assert_macros.svh"

module yaw_rate_kalman_zupt_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  gyro_valid,
    output logic                                  gyro_ready,
    input  logic signed [15:0]                    gyro_sample,
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output logic [24:0]                           yaw_angle,
    output logic signed [26:0]                    filtered_rate,
    output logic signed [15:0]                    bias_now,
    output logic                                  still_flag,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [kzu_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [23:0]                           cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL_RAW, S_RAW, S_DIV, S_KX, S_UPD_X, S_PK, S_UPD_P,
        S_ZUPT, S_RES, S_HEAD, S_WRAP, S_DONE
    } state_t;

    state_t state_reg;

    logic [17:0]        noise_r_reg;
    logic [15:0]        tick_period_reg;
    logic [23:0]        rate_scale_reg;

    logic [24:0]        heading_reg;
    logic signed [26:0] x_reg;
    logic [17:0]        cov_reg;
    logic               seed_reg;
    logic signed [15:0] bias_reg;
    logic [2:0]         qcount_reg;
    logic signed [23:0] residue_reg;
    logic               was_still_reg;
    logic [4:0]         turn_hold_reg;

    logic signed [15:0] sample_reg;
    logic signed [26:0] raw_reg;
    logic [17:0]        p_reg;
    logic [16:0]        k_reg;
    logic               held_reg;
    logic signed [29:0] h_reg;

    logic               out_valid_reg;
    logic [24:0]        yaw_out_reg;
    logic signed [26:0] rate_out_reg;
    logic signed [15:0] bias_out_reg;
    logic               still_out_reg;

    // Shared multiplier operands.
    logic signed [kzu_pkg::RATE_W-1:0] mul_a;
    logic signed [kzu_pkg::MB_W-1:0]   mul_b;
    logic signed [kzu_pkg::PROD_W-1:0] prod;

    kzu_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    logic [18:0]                      p_sum;
    logic [17:0]                      p_new;
    logic [kzu_pkg::DIV_DEN_W-1:0]    den;
    logic [kzu_pkg::DIV_NUM_W-1:0]    num;
    logic                             div_start;
    logic [kzu_pkg::DIV_Q_W-1:0]      div_q;
    kzu_pkg::div_status_t             div_st;

    kzu_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (num),
        .den    (den),
        .quot   (div_q),
        .status (div_st)
    );

    // Datapath terms taken from the registered product.
    logic signed [16:0]                diff;
    logic signed [kzu_pkg::PROD_W-1:0] r8;
    logic signed [kzu_pkg::PROD_W-1:0] r16;
    logic signed [26:0]                raw_c;
    logic                              raw_slow;
    logic                              raw_fast;
    logic [17:0]                       q_sel;
    logic signed [kzu_pkg::PROD_W:0]   x_sum;
    logic signed [26:0]                x_new;
    logic [17:0]                       cov_new;
    logic                              quiet;
    logic signed [24:0]                res_sum;
    logic signed [29:0]                h_sum;

    assign diff = 17'(sample_reg) - 17'(bias_reg);
    assign r8   = (prod + kzu_pkg::PROD_W'(128)) >>> 8;
    assign r16  = (prod + kzu_pkg::PROD_W'(32768)) >>> 16;

    always_comb
    begin
        if (r8 > kzu_pkg::PROD_W'(kzu_pkg::RATE_MAX))
            raw_c = kzu_pkg::RATE_MAX;
        else if (r8 < kzu_pkg::PROD_W'(kzu_pkg::RATE_MIN))
            raw_c = kzu_pkg::RATE_MIN;
        else
            raw_c = 27'(r8);
    end

    assign raw_slow = (raw_c < kzu_pkg::SLOW_LIMIT) && (raw_c > -kzu_pkg::SLOW_LIMIT);
    assign raw_fast = !((raw_c < kzu_pkg::FAST_LIMIT) && (raw_c > -kzu_pkg::FAST_LIMIT));
    assign q_sel    = raw_slow ? kzu_pkg::Q_SLOW : (raw_fast ? kzu_pkg::Q_FAST : kzu_pkg::Q_MID);

    assign p_sum = {1'b0, cov_reg} + {1'b0, q_sel};
    assign p_new = (p_sum > {1'b0, kzu_pkg::COV_MAX}) ? kzu_pkg::COV_MAX : p_sum[17:0];
    assign den   = {1'b0, p_new} + {1'b0, noise_r_reg};
    assign num   = {1'b0, p_new, 16'd0} + kzu_pkg::DIV_NUM_W'(den[18:1]);
    assign div_start = (state_reg == S_RAW) && !seed_reg;

    assign x_sum = (kzu_pkg::PROD_W+1)'(x_reg) + (kzu_pkg::PROD_W+1)'(r16);

    always_comb
    begin
        if (x_sum > (kzu_pkg::PROD_W+1)'(kzu_pkg::RATE_MAX))
            x_new = kzu_pkg::RATE_MAX;
        else if (x_sum < (kzu_pkg::PROD_W+1)'(kzu_pkg::RATE_MIN))
            x_new = kzu_pkg::RATE_MIN;
        else
            x_new = 27'(x_sum);
    end

    always_comb
    begin
        if (r16 < 0)
            cov_new = '0;
        else if (r16 > kzu_pkg::PROD_W'(kzu_pkg::COV_MAX))
            cov_new = kzu_pkg::COV_MAX;
        else
            cov_new = r16[17:0];
    end

    assign quiet   = (x_reg < kzu_pkg::QUIET_LIMIT) && (x_reg > -kzu_pkg::QUIET_LIMIT);
    assign res_sum = 25'(residue_reg) + 25'(r16);
    assign h_sum   = 30'(heading_reg) + 30'(r16);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MUL_RAW:
            begin
                mul_a = kzu_pkg::RATE_W'(diff);
                mul_b = kzu_pkg::MB_W'(rate_scale_reg);
            end
            S_KX:
            begin
                mul_a = 28'(raw_reg) - 28'(x_reg);
                mul_b = kzu_pkg::MB_W'(k_reg);
            end
            S_PK:
            begin
                mul_a = kzu_pkg::RATE_W'(p_reg);
                mul_b = kzu_pkg::MB_W'(18'd65536 - 18'(k_reg));
            end
            S_ZUPT:
            begin
                mul_a = kzu_pkg::RATE_W'(x_reg);
                mul_b = kzu_pkg::MB_W'(kzu_pkg::LEAK_GAIN);
            end
            S_RES:
            begin
                mul_a = kzu_pkg::RATE_W'(x_reg);
                mul_b = kzu_pkg::MB_W'(tick_period_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            noise_r_reg     <= kzu_pkg::NOISE_R_RESET;
            tick_period_reg <= kzu_pkg::TICK_PERIOD_RESET;
            rate_scale_reg  <= kzu_pkg::RATE_SCALE_RESET;
            heading_reg     <= '0;
            x_reg           <= '0;
            cov_reg         <= kzu_pkg::COV_RESET;
            seed_reg        <= 1'b1;
            bias_reg        <= '0;
            qcount_reg      <= '0;
            residue_reg     <= '0;
            was_still_reg   <= 1'b0;
            turn_hold_reg   <= '0;
            held_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            // In S_DONE the output register is handled by the sequencer below.
            if (out_valid_reg && res_ready && state_reg != S_DONE)
                out_valid_reg <= 1'b0;

            if (cfg_valid)
            begin
                unique case (cfg_index)
                    kzu_pkg::REG_NOISE_R:     noise_r_reg <= cfg_data[17:0];
                    kzu_pkg::REG_BIAS_LOAD:   bias_reg <= cfg_data[15:0];
                    kzu_pkg::REG_TICK_PERIOD: tick_period_reg <= cfg_data[15:0];
                    kzu_pkg::REG_RATE_SCALE:  rate_scale_reg <= cfg_data;
                    default: ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (gyro_valid)
                    begin
                        sample_reg <= gyro_sample;
                        state_reg  <= S_MUL_RAW;
                    end
                end
                S_MUL_RAW:
                    state_reg <= S_RAW;
                S_RAW:
                begin
                    raw_reg  <= raw_c;
                    p_reg    <= p_new;
                    held_reg <= 1'b0;
                    if (raw_fast)
                        turn_hold_reg <= 5'(kzu_pkg::TURN_HOLD_TICKS);
                    else if (turn_hold_reg != '0)
                        turn_hold_reg <= turn_hold_reg - 1'b1;
                    if (seed_reg)
                    begin
                        x_reg     <= raw_c;
                        seed_reg  <= 1'b0;
                        state_reg <= S_ZUPT;
                    end
                    else
                        state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_st.done)
                    begin
                        k_reg     <= div_q;
                        state_reg <= S_KX;
                    end
                end
                S_KX:
                    state_reg <= S_UPD_X;
                S_UPD_X:
                begin
                    x_reg     <= x_new;
                    state_reg <= S_PK;
                end
                S_PK:
                    state_reg <= S_UPD_P;
                S_UPD_P:
                begin
                    cov_reg   <= cov_new;
                    state_reg <= S_ZUPT;
                end
                S_ZUPT:
                begin
                    if (turn_hold_reg == '0 && quiet)
                    begin
                        if (qcount_reg >= 3'(kzu_pkg::QUIET_TICKS - 1))
                        begin
                            qcount_reg    <= 3'(kzu_pkg::QUIET_TICKS);
                            was_still_reg <= 1'b1;
                            held_reg      <= 1'b1;
                        end
                        else
                            qcount_reg <= qcount_reg + 1'b1;
                    end
                    else
                    begin
                        if (!quiet)
                            qcount_reg <= '0;
                        if (was_still_reg)
                        begin
                            was_still_reg <= 1'b0;
                            residue_reg   <= '0;
                        end
                    end
                    state_reg <= S_RES;
                end
                S_RES:
                begin
                    if (held_reg)
                    begin
                        if (res_sum > kzu_pkg::RESIDUE_TRIP)
                        begin
                            if (bias_reg != 16'sh7FFF)
                                bias_reg <= bias_reg + 1'b1;
                            residue_reg <= '0;
                        end
                        else if (res_sum < -kzu_pkg::RESIDUE_TRIP)
                        begin
                            if (bias_reg != 16'sh8000)
                                bias_reg <= bias_reg - 1'b1;
                            residue_reg <= '0;
                        end
                        else
                            residue_reg <= 24'(res_sum);
                    end
                    state_reg <= S_HEAD;
                end
                S_HEAD:
                begin
                    h_reg     <= h_sum;
                    state_reg <= held_reg ? S_DONE : S_WRAP;
                end
                S_WRAP:
                begin
                    // At most three turns of correction either way.
                    if (h_reg >= kzu_pkg::FULL_TURN)
                        h_reg <= h_reg - kzu_pkg::FULL_TURN;
                    else if (h_reg < 0)
                        h_reg <= h_reg + kzu_pkg::FULL_TURN;
                    else
                    begin
                        heading_reg <= h_reg[24:0];
                        state_reg   <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || res_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        yaw_out_reg   <= heading_reg;
                        rate_out_reg  <= x_reg;
                        bias_out_reg  <= bias_reg;
                        still_out_reg <= held_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign gyro_ready    = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign res_valid     = out_valid_reg;
    assign yaw_angle     = yaw_out_reg;
    assign filtered_rate = rate_out_reg;
    assign bias_now      = bias_out_reg;
    assign still_flag    = still_out_reg;

    `KZU_ASSERT_ALWAYS(a_heading_range, heading_reg < kzu_pkg::FULL_TURN[24:0])
    `KZU_ASSERT_ALWAYS(a_quiet_count_max, qcount_reg <= 3'(kzu_pkg::QUIET_TICKS))
    `KZU_ASSERT_IMPLIES(a_held_no_turn, held_reg, turn_hold_reg == '0)
    `KZU_ASSERT_IMPLIES(a_div_in_div_state, div_st.busy, state_reg == S_DIV)

endmodule
